// ===== rtl/blocked_process_wakeup_queue_defines.svh =====
// assertion macros for the wakeup queue rtl
`ifndef BLOCKED_PROCESS_WAKEUP_QUEUE_DEFINES_SVH
`define BLOCKED_PROCESS_WAKEUP_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, muted while reset is high
`define BPWQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds during reset
`define BPWQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPWQ_ASSERT(lbl, clk, rst, prop, msg)
`define BPWQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/bpwq_pkg.sv =====
// types, constants and helpers for the wakeup queue
package bpwq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W        = 16;
  localparam int SEC_W       = 32;
  localparam int NS_W        = 30;
  localparam int ACT_W       = 2;
  localparam int ENTRY_W     = ID_W + SEC_W + NS_W;

  localparam int S_DATA_W    = ((ENTRY_W + 7) / 8) * 8;
  localparam int S_USER_W    = ACT_W;
  localparam int M_DATA_W    = ID_W;
  localparam int M_USER_W    = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ENQ = 2'd0,
    ACT_DEQ = 2'd1,
    ACT_RDY = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_t;

  // one stored queue entry
  typedef struct packed {
    logic [NS_W-1:0]  ns;
    logic [SEC_W-1:0] secs;
    logic [ID_W-1:0]  id;
  } entry_t;

  // one incoming command
  typedef struct packed {
    action_t          action;
    logic [ID_W-1:0]  id;
    logic [SEC_W-1:0] secs;
    logic [NS_W-1:0]  ns;
  } cmd_t;

  // one outgoing result
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            found;
    logic            reject;
  } result_t;

  // wake time at or before the current time, seconds first
  function automatic logic is_ready(input logic [SEC_W-1:0] ws, input logic [NS_W-1:0] wn,
                                    input logic [SEC_W-1:0] cs, input logic [NS_W-1:0] cn);
    is_ready = (ws < cs) || ((ws == cs) && (wn <= cn));
  endfunction

endpackage

// ===== rtl/bpwq_ram.sv =====
// simple dual port ram, one write and one registered read per cycle
module bpwq_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bpwq_ctrl.sv =====
// queue sequencer: enqueue, head scan and gap closing over the entry ram
`include "blocked_process_wakeup_queue_defines.svh"

module bpwq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  bpwq_pkg::cmd_t                cmd,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bpwq_pkg::result_t             res,
  output logic                          mem_we,
  output logic [bpwq_pkg::IDX_W-1:0]    mem_waddr,
  output bpwq_pkg::entry_t              mem_wdata,
  output logic [bpwq_pkg::IDX_W-1:0]    mem_raddr,
  input  bpwq_pkg::entry_t              mem_rdata
);

  bpwq_pkg::state_t                state, state_next;
  logic [bpwq_pkg::CNT_W-1:0]      count, count_next;
  logic [bpwq_pkg::CNT_W-1:0]      chk, chk_next;
  bpwq_pkg::action_t               act, act_next;
  logic [bpwq_pkg::SEC_W-1:0]      cur_secs, cur_secs_next;
  logic [bpwq_pkg::NS_W-1:0]       cur_ns, cur_ns_next;
  bpwq_pkg::result_t               result, result_next;

  logic                            accept;
  logic [bpwq_pkg::CNT_W-1:0]      chk_inc;
  logic [bpwq_pkg::CNT_W-1:0]      chk_dec;
  logic                            more;
  logic                            hit;
  logic                            full;
  logic                            empty;

  // helpers
  assign cmd_ready = (state == bpwq_pkg::ST_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign chk_inc   = chk + bpwq_pkg::CNT_W'(1);
  assign chk_dec   = chk - bpwq_pkg::CNT_W'(1);
  assign more      = (chk_inc < count);
  assign full      = (count == bpwq_pkg::CNT_W'(bpwq_pkg::QUEUE_DEPTH));
  assign empty     = (count == '0);
  // dequeue takes the head unconditionally, remove-ready checks the wake time
  assign hit       = (act == bpwq_pkg::ACT_DEQ) ||
                     bpwq_pkg::is_ready(mem_rdata.secs, mem_rdata.ns, cur_secs, cur_ns);

  assign res_valid = (state == bpwq_pkg::ST_RESP);
  assign res       = result;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bpwq_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd.action)
            bpwq_pkg::ACT_DEQ,
            bpwq_pkg::ACT_RDY: state_next = empty ? bpwq_pkg::ST_RESP : bpwq_pkg::ST_SCAN;
            default:           state_next = bpwq_pkg::ST_RESP;
          endcase
        end
      end
      bpwq_pkg::ST_SCAN: begin
        if (hit) begin
          state_next = more ? bpwq_pkg::ST_SHIFT : bpwq_pkg::ST_RESP;
        end else begin
          state_next = more ? bpwq_pkg::ST_SCAN : bpwq_pkg::ST_RESP;
        end
      end
      bpwq_pkg::ST_SHIFT: begin
        state_next = more ? bpwq_pkg::ST_SHIFT : bpwq_pkg::ST_RESP;
      end
      bpwq_pkg::ST_RESP: begin
        if (res_ready) begin
          state_next = bpwq_pkg::ST_IDLE;
        end
      end
      default: state_next = bpwq_pkg::ST_IDLE;
    endcase
  end

  // ram accesses and datapath updates
  always_comb begin
    count_next    = count;
    chk_next      = chk;
    act_next      = act;
    cur_secs_next = cur_secs;
    cur_ns_next   = cur_ns;
    result_next   = result;
    mem_we        = 1'b0;
    mem_waddr     = chk_dec[bpwq_pkg::IDX_W-1:0];
    mem_wdata     = mem_rdata;
    // outside idle, the entry after the one now arriving is fetched ahead
    mem_raddr     = chk_inc[bpwq_pkg::IDX_W-1:0];
    case (state)
      bpwq_pkg::ST_IDLE: begin
        mem_raddr = '0;
        if (accept) begin
          act_next      = cmd.action;
          cur_secs_next = cmd.secs;
          cur_ns_next   = cmd.ns;
          chk_next      = '0;
          result_next   = '0;
          if (cmd.action == bpwq_pkg::ACT_ENQ) begin
            if (full) begin
              result_next.reject = 1'b1;
            end else begin
              mem_we            = 1'b1;
              mem_waddr         = count[bpwq_pkg::IDX_W-1:0];
              mem_wdata.id      = cmd.id;
              mem_wdata.secs    = cmd.secs;
              mem_wdata.ns      = cmd.ns;
              count_next        = count + bpwq_pkg::CNT_W'(1);
              result_next.found = 1'b1;
            end
          end
        end
      end
      bpwq_pkg::ST_SCAN: begin
        if (hit) begin
          result_next.id    = mem_rdata.id;
          result_next.found = 1'b1;
          if (more) begin
            chk_next = chk_inc;
          end else begin
            count_next = count - bpwq_pkg::CNT_W'(1);
          end
        end else if (more) begin
          chk_next = chk_inc;
        end
      end
      bpwq_pkg::ST_SHIFT: begin
        // move the arriving entry one slot toward the head
        mem_we = 1'b1;
        if (more) begin
          chk_next = chk_inc;
        end else begin
          count_next = count - bpwq_pkg::CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpwq_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chk      <= chk_next;
    act      <= act_next;
    cur_secs <= cur_secs_next;
    cur_ns   <= cur_ns_next;
    result   <= result_next;
  end

  `BPWQ_ASSERT(a_count_bound, clk, rst, count <= bpwq_pkg::CNT_W'(bpwq_pkg::QUEUE_DEPTH), "entry count above depth")
  `BPWQ_ASSERT(a_walk_in_range, clk, rst, (state == bpwq_pkg::ST_SCAN || state == bpwq_pkg::ST_SHIFT) |-> chk < count, "scan index outside the live entries")
  `BPWQ_ASSERT(a_enq_grows, clk, rst, (accept && cmd.action == bpwq_pkg::ACT_ENQ && !full) |=> count == $past(count) + 1'b1, "accepted enqueue did not grow the queue")
  `BPWQ_ASSERT(a_result_flags, clk, rst, res_valid |-> !(result.found && result.reject), "found and reject both set")
  `BPWQ_ASSERT(a_idle_id_zero, clk, rst, (res_valid && !result.found) |-> result.id == '0, "nonzero id without a removal")

endmodule

// ===== rtl/blocked_process_wakeup_queue.sv =====
// top level of the blocked process wakeup queue
//
// Ordered queue of up to QUEUE_DEPTH process entries (id plus wake-up time) held in
// one dual port ram with a registered read. Command kind is on s_tuser:
// enqueue appends at the tail, dequeue pops the head, remove-ready pops the first entry
// whose wake time is at or before the time given, keeping the order of the rest. Every
// command gives exactly one result transfer. Enqueue goes from the idle state straight
// to the result state. Dequeue and remove-ready walk the queue one entry per cycle
// through the ram read port, first to find the entry and then to close the gap. A
// finished result sits in the output register while the next command is taken. No
// clearing pass after reset.
module blocked_process_wakeup_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // proc_id [15:0], time_seconds [47:16], time_nanoseconds [77:48], zero pad
  input  logic [bpwq_pkg::S_DATA_W-1:0] s_tdata,
  // action [1:0]
  input  logic [bpwq_pkg::S_USER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // removed_id [15:0]
  output logic [bpwq_pkg::M_DATA_W-1:0] m_tdata,
  // found [0], full_reject [1]
  output logic [bpwq_pkg::M_USER_W-1:0] m_tuser
);

  bpwq_pkg::cmd_t                 cmd;
  bpwq_pkg::result_t              res;
  bpwq_pkg::result_t              out_res;
  logic                           res_valid;
  logic                           res_ready;
  logic                           mem_we;
  logic [bpwq_pkg::IDX_W-1:0]     mem_waddr;
  logic [bpwq_pkg::IDX_W-1:0]     mem_raddr;
  bpwq_pkg::entry_t               mem_wdata;
  bpwq_pkg::entry_t               mem_rdata;

  // unpack the input transfer
  assign cmd.action = bpwq_pkg::action_t'(s_tuser[bpwq_pkg::ACT_W-1:0]);
  assign cmd.id     = s_tdata[bpwq_pkg::ID_W-1:0];
  assign cmd.secs   = s_tdata[bpwq_pkg::ID_W +: bpwq_pkg::SEC_W];
  assign cmd.ns     = s_tdata[bpwq_pkg::ID_W + bpwq_pkg::SEC_W +: bpwq_pkg::NS_W];

  bpwq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_tvalid),
    .cmd_ready (s_tready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bpwq_ram #(
    .DATA_W (bpwq_pkg::ENTRY_W),
    .DEPTH  (bpwq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register, free when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  // pack the output transfer
  assign m_tdata = out_res.id;
  assign m_tuser = {out_res.reject, out_res.found};

endmodule
